>>> src/ihex_pkg.sv
// Package for the hex record parser: result type, event codes, record
// types and fixed constants. No dependencies.
`default_nettype none

package ihex_pkg;

  // Event codes carried by one result
  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_LINE  = 2'd1,
    EV_END   = 2'd2,
    EV_ERROR = 2'd3
  } event_e;

  typedef struct packed {
    event_e      ev;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [23:0] total;
  } ihex_result_t;

  // Characters
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEG     = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;
  localparam logic [7:0] BASE_REC_LEN = 8'd2;

  // Line layout: colon, length, address, type occupy positions 0 to 8
  localparam logic [9:0] POS_LEN_END  = 10'd2;
  localparam logic [9:0] POS_ADR_HI   = 10'd4;
  localparam logic [9:0] POS_ADR_END  = 10'd6;
  localparam logic [9:0] POS_TYPE_END = 10'd8;
  localparam logic [9:0] POS_CSUM_HI  = 10'd10;
  localparam logic [9:0] HDR_CHARS    = 10'd11;
  localparam logic [9:0] POS_MAX      = 10'd1023;

  localparam logic [31:0] IMAGE_LIMIT_RST = 32'h0002_0000;
  localparam logic [23:0] TOTAL_MAX       = 24'hFF_FFFF;

  // Decode one hex digit: bit 4 flags a valid digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

>>> src/ihex_in_stage.sv
// Input register of the hex record parser: holds one request until the
// parsing step takes it. Uses no package.
`default_nettype none

module ihex_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       advance_i,
  output logic            item_valid_o,
  output logic            item_kind_o,
  output logic [7:0]      item_char_o
);

  logic       valid_q, valid_d;
  logic       kind_q;
  logic [7:0] char_q;

  // Take a new request whenever the held one leaves or none is held
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_kind_o  = kind_q;
  assign item_char_o  = char_q;

endmodule

`default_nettype wire

>>> src/ihex_core.sv
// Parsing step of the hex record parser: line state, base, totals, the
// image limit register and the per-character update. Depends on ihex_pkg.
`default_nettype none

module ihex_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          step_i,
  input  wire logic          kind_i,
  input  wire logic [7:0]    char_i,
  output logic               res_valid_o,
  output ihex_pkg::ihex_result_t res_o
);

  import ihex_pkg::*;

  typedef enum logic [1:0] {
    FIN_LOADING = 2'd0,
    FIN_END     = 2'd1,
    FIN_ERROR   = 2'd2
  } finish_e;

  logic [31:0] limit_q;
  logic [9:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] field_q, field_d;
  logic [7:0]  offset_q, offset_d;
  logic [31:0] base_q, base_d;
  logic [23:0] total_q, total_d;
  logic        bad_q, bad_d;
  finish_e     fin_q, fin_d;

  logic [4:0]  hex;
  logic        hex_ok;
  logic [3:0]  digit;
  logic [9:0]  end_pos;
  logic [15:0] field_sh;
  logic [7:0]  nib_add;
  logic [32:0] top;
  logic [24:0] total_sum;
  logic [31:0] byte_addr;
  logic        fail;
  logic        emit;
  event_e      ev;
  logic [31:0] ev_addr;
  logic [7:0]  ev_data;

  // Decode the character and precompute the shared arithmetic
  assign hex       = hex_digit(char_i);
  assign hex_ok    = hex[4];
  assign digit     = hex[3:0];
  assign end_pos   = POS_CSUM_HI + {1'b0, len_q, 1'b0};
  assign field_sh  = {field_q[11:0], digit};
  assign nib_add   = (pos_q == end_pos) ? {4'd0, digit} : {digit, 4'd0};
  assign top       = {1'b0, base_q} + {17'd0, addr_q} + {25'd0, len_q};
  assign total_sum = {1'b0, total_q} + {17'd0, len_q};
  assign byte_addr = base_q + {16'd0, addr_q} + {24'd0, offset_q};

  // Next state and result for one request
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    addr_d   = addr_q;
    type_d   = type_q;
    sum_d    = sum_q;
    field_d  = field_q;
    offset_d = offset_q;
    base_d   = base_q;
    total_d  = total_q;
    bad_d    = bad_q;
    fin_d    = fin_q;
    fail     = 1'b0;
    emit     = 1'b0;
    ev       = EV_LINE;
    ev_addr  = 32'd0;
    ev_data  = 8'd0;

    if (kind_i) begin
      // Start a new file
      pos_d    = 10'd0;
      len_d    = 8'd0;
      addr_d   = 16'd0;
      type_d   = 8'd0;
      sum_d    = 8'd0;
      field_d  = 16'd0;
      offset_d = 8'd0;
      base_d   = 32'd0;
      total_d  = 24'd0;
      bad_d    = 1'b0;
      fin_d    = FIN_LOADING;
    end else if (fin_q != FIN_LOADING) begin
      // Load stopped: drop characters
    end else if (char_i == CHAR_LF) begin
      if (pos_q < HDR_CHARS || pos_q < end_pos + 10'd1) begin
        fail = 1'b1;
      end else begin
        pos_d = 10'd0;
      end
    end else if (pos_q > POS_CSUM_HI && pos_q > end_pos) begin
      // Trailing characters after the checksum
    end else begin
      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 10'd1;
      if (pos_q == 10'd0) begin
        if (char_i != CHAR_COLON) begin
          fail = 1'b1;
        end else begin
          sum_d    = 8'd0;
          field_d  = 16'd0;
          offset_d = 8'd0;
          bad_d    = 1'b0;
        end
      end else if (pos_q <= POS_TYPE_END) begin
        // Header digits
        if (!hex_ok) begin
          fail = 1'b1;
        end else begin
          field_d = field_sh;
          priority if (pos_q == POS_LEN_END) begin
            len_d = field_sh[7:0];
            sum_d = sum_q + field_sh[7:0];
          end else if (pos_q == POS_ADR_HI) begin
            sum_d = sum_q + field_sh[7:0];
          end else if (pos_q == POS_ADR_END) begin
            addr_d = field_sh;
            sum_d  = sum_q + field_sh[7:0];
          end else if (pos_q == POS_TYPE_END) begin
            type_d = field_sh[7:0];
            sum_d  = sum_q + field_sh[7:0];
            if (top >= {1'b0, limit_q}) begin
              fail = 1'b1;
            end else if (field_sh[7:0] == REC_DATA) begin
              total_d = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[23:0];
            end
          end else begin
            // Odd header digit: shift only
          end
        end
      end else if (type_q == REC_DATA) begin
        // Data record payload and checksum
        if (!hex_ok) begin
          fail = 1'b1;
        end else if (pos_q + 10'd1 >= end_pos) begin
          sum_d = sum_q + nib_add;
          if (pos_q == end_pos) begin
            if (sum_d != 8'd0) begin
              fail = 1'b1;
            end else begin
              emit = 1'b1;
              ev   = EV_LINE;
            end
          end
        end else begin
          field_d = field_sh;
          if (!pos_q[0]) begin
            sum_d    = sum_q + field_sh[7:0];
            offset_d = offset_q + 8'd1;
            emit     = 1'b1;
            ev       = EV_BYTE;
            ev_addr  = byte_addr;
            ev_data  = field_sh[7:0];
          end
        end
      end else if (type_q == REC_EOF) begin
        if (pos_q == end_pos) begin
          fin_d = FIN_END;
          emit  = 1'b1;
          ev    = EV_END;
        end
      end else if ((type_q == REC_SEG || type_q == REC_LINEAR) && len_q == BASE_REC_LEN) begin
        // Base record: a bad digit or checksum leaves the base alone
        if (!hex_ok) begin
          bad_d = 1'b1;
        end else if (pos_q + 10'd1 >= end_pos) begin
          sum_d = sum_q + nib_add;
        end else begin
          field_d = field_sh;
          if (!pos_q[0]) begin
            sum_d = sum_q + field_sh[7:0];
          end
        end
        if (pos_q == end_pos) begin
          if (!bad_d && sum_d == 8'd0) begin
            base_d = (type_q == REC_SEG) ? {12'd0, field_d, 4'd0} : {field_d, 16'd0};
          end
          emit = 1'b1;
          ev   = EV_LINE;
        end
      end else begin
        // Skipped record type
        if (pos_q == end_pos) begin
          emit = 1'b1;
          ev   = EV_LINE;
        end
      end
    end

    if (fail) begin
      fin_d   = FIN_ERROR;
      emit    = 1'b1;
      ev      = EV_ERROR;
      ev_addr = 32'd0;
      ev_data = 8'd0;
    end
  end

  assign res_valid_o = step_i && emit;
  assign res_o       = '{ev: ev, addr: ev_addr, data: ev_data, total: total_d};

  // Hold the limit register and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= IMAGE_LIMIT_RST;
      pos_q    <= 10'd0;
      len_q    <= 8'd0;
      addr_q   <= 16'd0;
      type_q   <= 8'd0;
      sum_q    <= 8'd0;
      field_q  <= 16'd0;
      offset_q <= 8'd0;
      base_q   <= 32'd0;
      total_q  <= 24'd0;
      bad_q    <= 1'b0;
      fin_q    <= FIN_LOADING;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (step_i) begin
        pos_q    <= pos_d;
        len_q    <= len_d;
        addr_q   <= addr_d;
        type_q   <= type_d;
        sum_q    <= sum_d;
        field_q  <= field_d;
        offset_q <= offset_d;
        base_q   <= base_d;
        total_q  <= total_d;
        bad_q    <= bad_d;
        fin_q    <= fin_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ihex_out_stage.sv
// Result register of the hex record parser: holds one result until the
// receiver takes it. Depends on ihex_pkg.
`default_nettype none

module ihex_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic           res_valid_i,
  input  wire ihex_pkg::ihex_result_t res_i,
  output logic                slot_free_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ihex_pkg::ihex_result_t res_o
);

  import ihex_pkg::*;

  logic         valid_q, valid_d;
  ihex_result_t res_q;

  // The slot is free when empty or when its result leaves this cycle
  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> src/intel_hex_record_parser.sv
// Hex record parser top level: input register, parsing step, result
// register. Depends on ihex_pkg, ihex_in_stage, ihex_core, ihex_out_stage.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one request per
// file character (kind_i = 0, char_code_i) or a start-of-file marker
// (kind_i = 1), which clears base, totals, flags and line state. The output
// channel (out_valid_o/out_ready_i) carries at most one result per request:
// a byte write, line accepted, end record or sticky error, always with the
// running byte total. cfg_we_i writes cfg_wdata_i into the image limit.
// An accepted request waits in the input register; once the result slot is
// free, its result is computed and enters the result register.
// Throughput: one request per cycle while the receiver keeps up; the whole
// per-character update is combinational logic between the input register
// and the result register. A stalled receiver holds the result register;
// the next request is still parsed into it as soon as the held result is
// taken, and the input side stalls only while both registers are full.
// Reset: both registers empty, parser state cleared, image limit 131072.
`default_nettype none

module intel_hex_record_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic [31:0]      write_address_o,
  output logic [7:0]       write_data_o,
  output logic [23:0]      bytes_loaded_o
);

  import ihex_pkg::*;

  logic         item_valid;
  logic         item_kind;
  logic [7:0]   item_char;
  logic         slot_free;
  logic         advance;
  logic         res_valid;
  ihex_result_t res;
  ihex_result_t out_res;

  // Advance a held request when the result slot can take its result
  assign advance = item_valid && slot_free;

  ihex_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_kind_o  (item_kind),
    .item_char_o  (item_char)
  );

  ihex_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .kind_i      (item_kind),
    .char_i      (item_char),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ihex_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign event_res_o     = out_res.ev;
  assign write_address_o = out_res.addr;
  assign write_data_o    = out_res.data;
  assign bytes_loaded_o  = out_res.total;

endmodule

`default_nettype wire

>>> tb/ihex_check_pkg.sv
// Scoreboard package for the hex record parser testbench: character codes,
// load state and the class that predicts and checks parser results.
// Depends on ihex_pkg for the result type, event codes and line layout.
package ihex_check_pkg;
  import ihex_pkg::*;

  localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHAR_DIGIT9  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam int         MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    LOAD_ACTIVE,
    LOAD_ENDED,
    LOAD_FAILED
  } load_e;

  class hex_scoreboard;
    logic [31:0]  limit;
    logic [9:0]   pos;
    logic [7:0]   rec_len;
    logic [15:0]  rec_addr;
    logic [7:0]   rec_type;
    logic [7:0]   csum;
    logic [15:0]  shifter;
    logic [7:0]   offset;
    logic [31:0]  base;
    logic [23:0]  total;
    bit           line_bad;
    load_e        done;
    ihex_result_t expected_q[$];
    int           mismatches;

    function new();
      limit      = IMAGE_LIMIT_RST;
      mismatches = 0;
      start_file();
    endfunction

    // Value of a hex digit, -1 for any other character
    static function int digit_value(logic [7:0] c);
      if (c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9) return int'(c - CHAR_DIGIT0);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return int'(c - CHAR_UPPER_A) + 10;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return int'(c - CHAR_LOWER_A) + 10;
      return -1;
    endfunction

    function void start_file();
      pos      = '0;
      rec_len  = '0;
      rec_addr = '0;
      rec_type = '0;
      csum     = '0;
      shifter  = '0;
      offset   = '0;
      base     = '0;
      total    = '0;
      line_bad = 1'b0;
      done     = LOAD_ACTIVE;
    endfunction

    function void set_limit(logic [31:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_result(event_e ev, logic [31:0] addr, logic [7:0] data);
      ihex_result_t r;
      r.ev    = ev;
      r.addr  = addr;
      r.data  = data;
      r.total = total;
      expected_q.push_back(r);
    endfunction

    function void push_error();
      done = LOAD_FAILED;
      push_result(EV_ERROR, '0, '0);
    endfunction

    // Advance the parser by one request; return 0 if the parser ignores it
    function bit note_request(logic kind, logic [7:0] c);
      int unsigned p;
      int unsigned last;
      int          d;
      logic [3:0]  nib;
      logic [32:0] top;
      logic [31:0] addr;
      p    = pos;
      last = POS_CSUM_HI + 2 * rec_len;
      if (kind) begin
        start_file();
        return 1'b1;
      end
      if (done != LOAD_ACTIVE) return 1'b0;

      // Newline: fail a short line, else restart the line
      if (c == CHAR_LF) begin
        if (p < HDR_CHARS || p < last + 1) push_error();
        else pos = '0;
        return 1'b1;
      end
      if (p > POS_CSUM_HI && p > last) return 1'b0;
      pos = (p < POS_MAX) ? pos + 10'd1 : POS_MAX;

      if (p == 0) begin
        if (c != CHAR_COLON) begin
          push_error();
        end else begin
          csum     = '0;
          shifter  = '0;
          offset   = '0;
          line_bad = 1'b0;
        end
        return 1'b1;
      end
      d   = digit_value(c);
      nib = d[3:0];

      // Header: length, address, type, then the range check
      if (p <= POS_TYPE_END) begin
        if (d < 0) begin
          push_error();
          return 1'b1;
        end
        shifter = {shifter[11:0], nib};
        if (p == POS_LEN_END) begin
          rec_len = shifter[7:0];
          csum    = csum + rec_len;
        end else if (p == POS_ADR_HI) begin
          csum = csum + shifter[7:0];
        end else if (p == POS_ADR_END) begin
          rec_addr = shifter;
          csum     = csum + shifter[7:0];
        end else if (p == POS_TYPE_END) begin
          rec_type = shifter[7:0];
          csum     = csum + rec_type;
          top      = {1'b0, base} + rec_addr + rec_len;
          if (top >= {1'b0, limit}) push_error();
          else if (rec_type == REC_DATA)
            total = (total > TOTAL_MAX - rec_len) ? TOTAL_MAX : total + rec_len;
        end
        return 1'b1;
      end

      // Data record: one write per pair, checksum at the last digit
      if (rec_type == REC_DATA) begin
        if (d < 0) begin
          push_error();
          return 1'b1;
        end
        if (p + 1 >= last) begin
          csum = csum + ((p == last) ? {4'h0, nib} : {nib, 4'h0});
          if (p == last) begin
            if (csum != 8'd0) push_error();
            else push_result(EV_LINE, '0, '0);
          end
          return 1'b1;
        end
        shifter = {shifter[11:0], nib};
        if (p % 2 == 0) begin
          addr   = base + 32'(rec_addr) + 32'(offset);
          csum   = csum + shifter[7:0];
          offset = offset + 8'd1;
          push_result(EV_BYTE, addr, shifter[7:0]);
        end
        return 1'b1;
      end

      if (rec_type == REC_EOF) begin
        if (p == last) begin
          done = LOAD_ENDED;
          push_result(EV_END, '0, '0);
        end
        return 1'b1;
      end

      // Base record: a bad digit or checksum keeps the old base
      if ((rec_type == REC_SEG || rec_type == REC_LINEAR) && rec_len == BASE_REC_LEN) begin
        if (d < 0) begin
          line_bad = 1'b1;
        end else if (p + 1 >= last) begin
          csum = csum + ((p == last) ? {4'h0, nib} : {nib, 4'h0});
        end else begin
          shifter = {shifter[11:0], nib};
          if (p % 2 == 0) csum = csum + shifter[7:0];
        end
        if (p == last) begin
          if (!line_bad && csum == 8'd0)
            base = (rec_type == REC_SEG) ? {12'h0, shifter, 4'h0} : {shifter, 16'h0};
          push_result(EV_LINE, '0, '0);
        end
        return 1'b1;
      end

      // Skipped type: accept at the last checksum digit
      if (p == last) push_result(EV_LINE, '0, '0);
      return 1'b1;
    endfunction

    // Compare one delivered result against the oldest expected one
    function void check_result(logic [1:0] ev, logic [31:0] addr, logic [7:0] data,
                               logic [23:0] total_seen);
      ihex_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: ev %0d addr %h data %h total %0d",
                   ev, addr, data, total_seen);
        return;
      end
      want = expected_q.pop_front();
      if (want.ev !== ev || want.addr !== addr || want.data !== data ||
          want.total !== total_seen) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected ev %0d addr %h data %h total %0d, got ev %0d addr %h data %h total %0d",
                   want.ev, want.addr, want.data, want.total,
                   ev, addr, data, total_seen);
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top of the hex record parser testbench: clock, reset, request and result
// drivers, limit writes and the phased random stimulus.
// Depends on ihex_pkg, ihex_check_pkg and intel_hex_record_parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;
  import ihex_check_pkg::*;

  localparam int PHASES      = 6;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS  = 2_000_000;

  typedef enum int {
    FLAW_NONE,
    FLAW_TRAIL,
    FLAW_COLON,
    FLAW_DIGIT,
    FLAW_CSUM,
    FLAW_SHORT
  } flaw_e;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [31:0] cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        kind        = 1'b0;
  logic [7:0]  char_code   = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  event_res_o;
  logic [31:0] write_address_o;
  logic [7:0]  write_data_o;
  logic [23:0] bytes_loaded_o;

  hex_scoreboard sb;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            parsed_count  = 0;
  logic [7:0]    line_chars[$];
  int            phase_items[PHASES] = '{250, 250, 80, 250, 250, 320};

  intel_hex_record_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind),
    .char_code_i     (char_code),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .event_res_o     (event_res_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .bytes_loaded_o  (bytes_loaded_o)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Drop ready at random on the result side
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready)
      sb.check_result(event_res_o, write_address_o, write_data_o, bytes_loaded_o);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one request, hold it until accepted, then predict it
  task automatic send_request(logic k, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= c;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    if (sb.note_request(k, c)) parsed_count++;
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_request(1'b0, s[i]);
  endtask

  // Drain the parser: every result in, then the pipeline latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CHAR_LF || c == CHAR_COLON || hex_scoreboard::digit_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CHAR_DIGIT0 + 8'(v);
    return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v) - 8'd10;
  endfunction

  function automatic void push_hex(logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
  endfunction

  // Build one record line, then damage it as the flaw asks
  function automatic void build_record(logic [7:0] rtype, logic [7:0] len,
                                       logic [15:0] addr, flaw_e flaw);
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] base_val;
    int          i;
    int          cut;
    line_chars.delete();
    line_chars.push_back(CHAR_COLON);
    sum = len + addr[15:8] + addr[7:0] + rtype;
    push_hex(len);
    push_hex(addr[15:8]);
    push_hex(addr[7:0]);
    push_hex(rtype);
    case ($urandom_range(2))
      0:       base_val = '0;
      1:       base_val = 16'($urandom_range(3));
      default: base_val = 16'($urandom);
    endcase
    for (i = 0; i < len; i++) begin
      if (len == BASE_REC_LEN && (rtype == REC_SEG || rtype == REC_LINEAR))
        b = (i == 0) ? base_val[15:8] : base_val[7:0];
      else
        b = 8'($urandom);
      sum = sum + b;
      push_hex(b);
    end
    sum = ~sum + 8'd1;
    if (flaw == FLAW_CSUM) sum = sum ^ 8'($urandom_range(255, 1));
    push_hex(sum);
    case (flaw)
      FLAW_COLON: line_chars[0] = noise_char();
      FLAW_DIGIT: line_chars[$urandom_range(line_chars.size() - 1, 1)] = noise_char();
      FLAW_SHORT: begin
        cut = $urandom_range(line_chars.size() - 1, 0);
        while (line_chars.size() > cut) void'(line_chars.pop_back());
      end
      FLAW_TRAIL: repeat ($urandom_range(4, 1)) line_chars.push_back(noise_char());
      default: ;
    endcase
    line_chars.push_back(CHAR_LF);
  endfunction

  // Send one random line, mostly well formed; restart the file once stopped
  task automatic send_random_line();
    int          r;
    logic [7:0]  rtype;
    logic [7:0]  len;
    logic [15:0] addr;
    flaw_e       flaw;
    r    = $urandom_range(99);
    len  = ($urandom_range(99) == 0) ? 8'($urandom_range(255, 16)) : 8'($urandom_range(8));
    addr = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
    flaw = FLAW_NONE;
    if (r < 45) begin
      rtype = REC_DATA;
    end else if (r < 57) begin
      rtype = $urandom_range(1) ? REC_SEG : REC_LINEAR;
      if ($urandom_range(4) != 0) len = BASE_REC_LEN;
    end else if (r < 64) begin
      rtype = 8'($urandom);
    end else if (r < 68) begin
      rtype = REC_EOF;
      if ($urandom_range(1)) len = '0;
    end else if (r < 74) begin
      rtype = REC_DATA;
      flaw  = FLAW_TRAIL;
    end else if (r < 76) begin
      send_request(1'b0, 8'($urandom));
      return;
    end else if (r < 77) begin
      send_request(1'b1, 8'($urandom));
      return;
    end else begin
      case ($urandom_range(2))
        0:       rtype = REC_DATA;
        1:       rtype = $urandom_range(1) ? REC_SEG : REC_LINEAR;
        default: rtype = 8'($urandom);
      endcase
      if (rtype != REC_DATA && $urandom_range(1)) len = BASE_REC_LEN;
      flaw = flaw_e'($urandom_range(int'(FLAW_SHORT), int'(FLAW_COLON)));
    end
    build_record(rtype, len, addr, flaw);
    foreach (line_chars[i]) send_request(1'b0, line_chars[i]);
    if (sb.done != LOAD_ACTIVE) begin
      repeat ($urandom_range(2)) send_request(1'b0, 8'($urandom));
      send_request(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int          phase;
    int          target;
    logic [31:0] limit_val;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme address and data, then an end record in lower case
    send_idle_pct = 15;
    recv_idle_pct = 71;
    send_request(1'b1, 8'hFF);
    send_text(":02FFFF0000FF01\n");
    send_text(":00000001ff\n");

    for (phase = 0; phase < PHASES; phase++) begin
      // Swap the idle pattern every two phases, none in the last two
      case (phase / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        1:       limit_val = 32'hFFFF_FFFF;
        2:       limit_val = 32'd1;
        3:       limit_val = $urandom_range(32'h0003_0000, 32'h0000_0100);
        4:       limit_val = $urandom;
        default: limit_val = IMAGE_LIMIT_RST;
      endcase
      if (phase != 0) write_limit(limit_val);
      send_request(1'b1, 8'($urandom));
      target = parsed_count + phase_items[phase];
      while (parsed_count < target) send_random_line();
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
